[rtl/bir_pkg.sv]
`timescale 1ns / 1ps

package bir_pkg;

  // Widths fixed by the transaction format
  localparam int COORD_W  = 10;
  localparam int PIX_W    = 32;
  localparam int CHAN_W   = 8;
  localparam int VAL_W    = 16;
  localparam int CFG_W    = 11;
  // Clamped image dimensions, wide enough for the largest frame store
  localparam int DIM_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_CHAN = 4;

  // Defaults for the top level parameters
  localparam int OUT_DIM_DEF     = 512;
  localparam int SRC_MAX_DIM_DEF = 1024;

  localparam logic [CFG_W-1:0] SRC_DIM_RESET = CFG_W'(512);

  // Edges from the accept edge to the edge that takes the result
  localparam int PIPE_LAT = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 1'b0,
    CFG_SRC_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIX_W-1:0]   source_pixel;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] red_value;
    logic [VAL_W-1:0] green_value;
    logic [VAL_W-1:0] blue_value;
    logic [VAL_W-1:0] alpha_value;
  } out_item_t;

endpackage

[rtl/bilinear_image_resize.sv]
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// input     start, busy, in_item                    taken when start && !busy
// result    out_strobe, out_item                    one-cycle strobe, cannot stall
// config    cfg_we, cfg_index, cfg_wdata            written when cfg_we is high
//
// One transaction enters every cycle while busy is low; a request raises its result
// strobe from the output register after passing the stage registers (PIPE_LAT), and
// a store gives none and is written at the end of stage 1.
// The rate is set by the frame store: four banks split on the parity of x and y
// so the four neighbours of a sample come out of four read ports in the same cycle.
// Reset is synchronous and active low; busy registers the inverse of reset, so it is
// high while reset is held and until the first edge after release. The frame store
// itself is not cleared: pixels are undefined until stored. The result side cannot
// stall, so nothing in the pipeline ever holds.
module bilinear_image_resize
  import bir_pkg::*;
#(
  parameter int OUT_DIM     = OUT_DIM_DEF,     // power of two
  parameter int SRC_MAX_DIM = SRC_MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int OUT_SH  = $clog2(OUT_DIM);
  localparam int SRC_AW  = $clog2(SRC_MAX_DIM);
  localparam int HALF_AW = SRC_AW - 1;
  localparam int BANK_AW = 2 * HALF_AW;
  localparam int NX_W    = COORD_W + DIM_W;
  localparam int WT_W    = 2 * OUT_SH + 1;
  localparam int ACC_W   = 2 * OUT_SH + CHAN_W;
  localparam int RES_LSB = 2 * OUT_SH - CHAN_W;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] src_width_r, src_height_r;
  logic [DIM_W-1:0] w_eff_r, h_eff_r;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > SRC_MAX_DIM) begin
      r = DIM_W'(SRC_MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_DIM_RESET;
      src_height_r <= SRC_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the clamped sizes in registers behind the size registers; they settle after
  // a write, well inside the idle time that configuration needs.
  always_ff @(posedge clk) begin
    w_eff_r <= clamp_dim(src_width_r);
    h_eff_r <= clamp_dim(src_height_r);
  end

  // ---------------------------------------------------------------- accept
  logic busy_r;
  logic in_acc;

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy   = busy_r;
  assign in_acc = start && !busy_r;

  // ---------------------------------------------------------------- stage 1
  // Register the transaction. Stores write the frame store at the end of
  // this stage; requests start the scale multiply.
  logic               s1_vld_r, s1_func_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r;
  logic [PIX_W-1:0]   s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_func_r <= in_item.func;
    s1_x_r    <= in_item.coord_x;
    s1_y_r    <= in_item.coord_y;
    s1_pix_r  <= in_item.source_pixel;
  end

  // Store path: drop pixels outside the configured image
  logic              wr_en;
  logic [1:0]        wr_bank;
  logic [BANK_AW-1:0] wr_addr;
  logic [SRC_AW-1:0] st_x, st_y;

  assign st_x    = SRC_AW'(s1_x_r);
  assign st_y    = SRC_AW'(s1_y_r);
  assign wr_en   = s1_vld_r && !s1_func_r
                && (DIM_W'(s1_x_r) < w_eff_r) && (DIM_W'(s1_y_r) < h_eff_r);
  assign wr_bank = {st_y[0], st_x[0]};
  assign wr_addr = {st_y[SRC_AW-1:1], st_x[SRC_AW-1:1]};

  // Request path: saturate to the output grid, scale by the source size
  logic [COORD_W-1:0] rq_x, rq_y;

  assign rq_x = (32'(s1_x_r) >= OUT_DIM) ? COORD_W'(OUT_DIM - 1) : s1_x_r;
  assign rq_y = (32'(s1_y_r) >= OUT_DIM) ? COORD_W'(OUT_DIM - 1) : s1_y_r;

  // ---------------------------------------------------------------- stage 2
  logic            s2_vld_r;
  logic [NX_W-1:0] s2_nx_r, s2_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_func_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_nx_r <= NX_W'(rq_x) * NX_W'(w_eff_r);
    s2_ny_r <= NX_W'(rq_y) * NX_W'(h_eff_r);
  end

  // Split into integer and fraction; the right and lower neighbours clamp at
  // the image edge, where they fall onto the same pixel.
  logic [DIM_W-1:0]  x0, y0, x1, y1;
  logic [OUT_SH-1:0] fx, fy;
  logic [SRC_AW-1:0] ax0, ax1, ay0, ay1;
  logic [BANK_AW-1:0] rd_addr [4];
  logic [PIX_W-1:0]   rd_data [4];

  assign x0 = DIM_W'(s2_nx_r >> OUT_SH);
  assign y0 = DIM_W'(s2_ny_r >> OUT_SH);
  assign fx = s2_nx_r[OUT_SH-1:0];
  assign fy = s2_ny_r[OUT_SH-1:0];
  assign x1 = (x0 == w_eff_r - DIM_W'(1)) ? x0 : x0 + DIM_W'(1);
  assign y1 = (y0 == h_eff_r - DIM_W'(1)) ? y0 : y0 + DIM_W'(1);

  assign ax0 = SRC_AW'(x0);
  assign ax1 = SRC_AW'(x1);
  assign ay0 = SRC_AW'(y0);
  assign ay1 = SRC_AW'(y1);

  // Each bank takes whichever neighbour has its parity
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [SRC_AW-1:0] bx, by;
      bx = (ax0[0] == b[0]) ? ax0 : ax1;
      by = (ay0[0] == b[1]) ? ay0 : ay1;
      rd_addr[b] = {by[SRC_AW-1:1], bx[SRC_AW-1:1]};
    end
  end

  // A store writes at the end of stage 1 and a request reads at the end of stage 2,
  // so an earlier store always lands first and a later one meets the read at the
  // same edge at most, where the bank returns old data.
  bir_store #(
    .BANK_AW (BANK_AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .wr_data (s1_pix_r),
    .rd_en   (s2_vld_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------- stage 3
  logic              s3_vld_r;
  logic [OUT_SH-1:0] s3_fx_r, s3_fy_r;
  logic              s3_x0p_r, s3_x1p_r, s3_y0p_r, s3_y1p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_fx_r  <= fx;
    s3_fy_r  <= fy;
    s3_x0p_r <= x0[0];
    s3_x1p_r <= x1[0];
    s3_y0p_r <= y0[0];
    s3_y1p_r <= y1[0];
  end

  logic [OUT_SH:0] inv_fx, inv_fy;

  assign inv_fx = (OUT_SH+1)'(OUT_DIM) - (OUT_SH+1)'(s3_fx_r);
  assign inv_fy = (OUT_SH+1)'(OUT_DIM) - (OUT_SH+1)'(s3_fy_r);

  // ---------------------------------------------------------------- stage 4
  // Corner order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
  logic             s4_vld_r;
  logic [WT_W-1:0]  s4_wt_r  [4];
  logic [PIX_W-1:0] s4_pix_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_wt_r[0]  <= WT_W'(inv_fx) * WT_W'(inv_fy);
    s4_wt_r[1]  <= WT_W'(s3_fx_r) * WT_W'(inv_fy);
    s4_wt_r[2]  <= WT_W'(inv_fx) * WT_W'(s3_fy_r);
    s4_wt_r[3]  <= WT_W'(s3_fx_r) * WT_W'(s3_fy_r);
    s4_pix_r[0] <= rd_data[{s3_y0p_r, s3_x0p_r}];
    s4_pix_r[1] <= rd_data[{s3_y0p_r, s3_x1p_r}];
    s4_pix_r[2] <= rd_data[{s3_y1p_r, s3_x0p_r}];
    s4_pix_r[3] <= rd_data[{s3_y1p_r, s3_x1p_r}];
  end

  // ---------------------------------------------------------------- stage 5
  logic             s5_vld_r;
  logic [ACC_W-1:0] s5_prod_r [NUM_CHAN][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int k = 0; k < 4; k++) begin
        s5_prod_r[c][k] <= ACC_W'(s4_wt_r[k]) * ACC_W'(s4_pix_r[k][CHAN_W*c +: CHAN_W]);
      end
    end
  end

  // Sum the four corners and keep 8 fraction bits of the byte value
  logic [ACC_W-1:0] acc [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc[c] = s5_prod_r[c][0] + s5_prod_r[c][1] + s5_prod_r[c][2] + s5_prod_r[c][3];
    end
  end

  // ---------------------------------------------------------------- output
  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.red_value   <= acc[0][RES_LSB +: VAL_W];
    out_item_r.green_value <= acc[1][RES_LSB +: VAL_W];
    out_item_r.blue_value  <= acc[2][RES_LSB +: VAL_W];
    out_item_r.alpha_value <= acc[3][RES_LSB +: VAL_W];
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[rtl/bir_store.sv]
`timescale 1ns / 1ps

// Four-bank frame store: bank {y[0], x[0]}, one write port shared by all banks,
// one registered read port per bank. Read-first on a same-address collision.
module bir_store
  import bir_pkg::*;
#(
  parameter int BANK_AW = 18
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [1:0]         wr_bank,
  input  logic [BANK_AW-1:0] wr_addr,
  input  logic [PIX_W-1:0]   wr_data,
  input  logic               rd_en,
  input  logic [BANK_AW-1:0] rd_addr [4],
  output logic [PIX_W-1:0]   rd_data [4]
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [2**BANK_AW];
    logic [PIX_W-1:0] rd_data_r;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data_r <= mem[rd_addr[b]];
      end
    end

    assign rd_data[b] = rd_data_r;
  end

endmodule

[rtl/bir_checker.sv]
`timescale 1ns / 1ps

module bir_checker
  import bir_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_strobe
);

  logic req_acc, st_acc;

  assign req_acc = start && !busy && in_item.func;
  assign st_acc  = start && !busy && !in_item.func;

  // Reset silences the result channel
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  // Every accepted request gives exactly one result at the fixed latency
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |-> ##PIPE_LAT out_strobe)
    else $error("request transaction lost");

  // No result without a request accepted at the matching edge
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(req_acc, PIPE_LAT))
    else $error("result without request");

  // Stores give no result
  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    st_acc |-> ##PIPE_LAT !out_strobe)
    else $error("store transaction gave a result");

  // The block takes transactions again in the cycle after reset lifts
  a_ready: assert property (@(posedge clk) rst_n |=> !busy)
    else $error("busy held after reset");

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe)
);

[tb/tb_bilinear_image_resize.sv]
`timescale 1ns / 1ps

// Drives store and request transactions into the resizer, keeps its own copy of the
// frame store and size registers, and checks every result strobe against the blend
// that the copy predicts. Requests only ever touch pixels that were stored first.
module tb_bilinear_image_resize;
  import bir_pkg::*;

  localparam int OUT_DIM    = OUT_DIM_DEF;
  localparam int SRC_MAX    = SRC_MAX_DIM_DEF;
  localparam int HALF_CYCLE = 6;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 90;

  // Function codes of an input transaction
  localparam logic FUNC_STORE   = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow of the block: frame store (written pixels only) and size registers
  logic [PIX_W-1:0] frame_mem [int unsigned];
  logic [CFG_W-1:0] shadow_width = SRC_DIM_RESET;
  logic [CFG_W-1:0] shadow_height = SRC_DIM_RESET;

  out_item_t pending_pixels [$];
  out_item_t oldest_pixel;
  int        fault_count = 0;
  int        live_items = 0;
  int        burst_left = 4;
  int        idle_cycles = 0;

  bilinear_image_resize dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #HALF_CYCLE clk = 1'b1;
    #HALF_CYCLE clk = 1'b0;
  end

  // Size register as the block uses it: zero reads as one, oversize saturates
  function automatic int unsigned used_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SRC_MAX) return SRC_MAX;
    return 32'(v);
  endfunction

  // Sample position along one axis: left/top neighbour, clamped right/lower
  // neighbour and the fraction in units of 1/OUT_DIM
  function automatic void locate(input logic [COORD_W-1:0] c, input int unsigned dim,
                                 output int unsigned lo, output int unsigned hi,
                                 output int unsigned frac);
    int unsigned pos;
    int unsigned n;
    pos = (c >= OUT_DIM) ? OUT_DIM - 1 : c;
    n = pos * dim;
    lo = n / OUT_DIM;
    frac = n % OUT_DIM;
    if (lo > dim - 1) lo = dim - 1;
    hi = (lo + 1 < dim) ? lo + 1 : dim - 1;
  endfunction

  function automatic int unsigned pixel_addr(int unsigned x, int unsigned y);
    return y * SRC_MAX + x;
  endfunction

  function automatic logic [PIX_W-1:0] stored_pixel(int unsigned x, int unsigned y);
    if (frame_mem.exists(pixel_addr(x, y))) return frame_mem[pixel_addr(x, y)];
    return '0;
  endfunction

  // Exact bilinear blend of the four neighbours, truncated to 8 fraction bits
  function automatic out_item_t blend_pixel(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    int unsigned     x0, x1, fx, y0, y1, fy;
    logic [PIX_W-1:0] corner [NUM_CHAN];
    longint unsigned wt [NUM_CHAN];
    longint unsigned acc;
    logic [VAL_W-1:0] chan_val [NUM_CHAN];
    out_item_t       r;
    locate(cx, used_dim(shadow_width), x0, x1, fx);
    locate(cy, used_dim(shadow_height), y0, y1, fy);
    corner[0] = stored_pixel(x0, y0);
    corner[1] = stored_pixel(x1, y0);
    corner[2] = stored_pixel(x0, y1);
    corner[3] = stored_pixel(x1, y1);
    wt[0] = 64'((OUT_DIM - fx) * (OUT_DIM - fy));
    wt[1] = 64'(fx * (OUT_DIM - fy));
    wt[2] = 64'((OUT_DIM - fx) * fy);
    wt[3] = 64'(fx * fy);
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc = 0;
      for (int k = 0; k < NUM_CHAN; k++) acc += wt[k] * corner[k][CHAN_W*c +: CHAN_W];
      chan_val[c] = VAL_W'((acc * 256) / (OUT_DIM * OUT_DIM));
    end
    r.red_value   = chan_val[0];
    r.green_value = chan_val[1];
    r.blue_value  = chan_val[2];
    r.alpha_value = chan_val[3];
    return r;
  endfunction

  // Bias pixel content towards the all-zero and all-one extremes
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t ERROR %s", $realtime, msg);
  endtask

  // Send one transaction and hold it until accepted; update the shadow on acceptance
  task automatic send_item(in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.func == FUNC_STORE) begin
      if (it.coord_x < used_dim(shadow_width) && it.coord_y < used_dim(shadow_height)) begin
        frame_mem[pixel_addr(32'(it.coord_x), 32'(it.coord_y))] = it.source_pixel;
        live_items++;
      end
    end else begin
      pending_pixels.push_back(blend_pixel(it.coord_x, it.coord_y));
      live_items++;
    end
    // End of burst: drop start for a random gap, then pick the next burst length
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic store_pixel(int unsigned x, int unsigned y, logic [PIX_W-1:0] pix);
    in_item_t it;
    it.func         = FUNC_STORE;
    it.coord_x      = COORD_W'(x);
    it.coord_y      = COORD_W'(y);
    it.source_pixel = pix;
    send_item(it);
  endtask

  // Store any neighbour not yet written (or, with refresh, rewrite some), then request
  task automatic request_pixel(int unsigned cx, int unsigned cy, bit refresh);
    int unsigned x0, x1, fx, y0, y1, fy;
    int unsigned xs [4];
    int unsigned ys [4];
    in_item_t    it;
    locate(COORD_W'(cx), used_dim(shadow_width), x0, x1, fx);
    locate(COORD_W'(cy), used_dim(shadow_height), y0, y1, fy);
    xs = '{x0, x1, x0, x1};
    ys = '{y0, y0, y1, y1};
    for (int k = 0; k < 4; k++) begin
      if (!frame_mem.exists(pixel_addr(xs[k], ys[k])) || (refresh && $urandom_range(0, 1)))
        store_pixel(xs[k], ys[k], pick_pixel());
    end
    it.func         = FUNC_REQUEST;
    it.coord_x      = COORD_W'(cx);
    it.coord_y      = COORD_W'(cy);
    it.source_pixel = $urandom;
    send_item(it);
  endtask

  // Hold off the sender until every expected result is in, then let the pipe settle
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SRC_WIDTH) shadow_width = v;
    else shadow_height = v;
    @(posedge clk);
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    drain_results();
    write_reg(CFG_SRC_WIDTH, CFG_W'(w));
    write_reg(CFG_SRC_HEIGHT, CFG_W'(h));
  endtask

  // Mixed traffic: mostly well-formed requests, some in-image stores, some stray stores
  task automatic random_traffic(int quota);
    int base;
    int unsigned w, h;
    base = live_items;
    w = used_dim(shadow_width);
    h = used_dim(shadow_height);
    while (live_items - base < quota) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
          request_pixel(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, OUT_DIM - 1),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, OUT_DIM - 1),
                        $urandom_range(0, 3) == 0);
        13, 14, 15, 16:
          store_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1), pick_pixel());
        default:
          store_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      endcase
    end
  endtask

  // Reset size is 512 on both axes: results are plain copies, out-of-grid saturates
  task automatic test_reset_size_copy();
    store_pixel(0, 0, '0);
    store_pixel(OUT_DIM - 1, OUT_DIM - 1, '1);
    request_pixel(0, 0, 1'b0);
    request_pixel(1023, 1023, 1'b0);
    request_pixel(OUT_DIM - 1, 0, 1'b0);
  endtask

  // Smallest and largest sizes, plus register values outside the legal range
  task automatic test_size_extremes();
    set_size(1, 1);
    request_pixel(0, 0, 1'b0);
    request_pixel(OUT_DIM - 1, OUT_DIM - 1, 1'b1);
    set_size(0, 2047);
    request_pixel(300, 1023, 1'b0);
    set_size(SRC_MAX, SRC_MAX);
    request_pixel(OUT_DIM - 1, OUT_DIM - 1, 1'b0);
  endtask

  // Pixels keep their address across size changes; stores outside the image drop
  task automatic test_size_change();
    set_size(16, 16);
    store_pixel(5, 3, 32'h8040_2010);
    set_size(4, 4);
    store_pixel(5, 3, 32'h0102_0304);
    store_pixel(15, 15, '1);
    set_size(16, 16);
    request_pixel(160, 96, 1'b0);
    set_size(3, 5);
    request_pixel(100, 200, 1'b1);
  endtask

  task automatic test_random_sizes();
    for (int i = 0; i < 10; i++) begin
      case (i)
        0: set_size(1, 1);
        1: set_size(2, 5);
        2: set_size(3, 7);
        3: set_size(16, 9);
        4: set_size(OUT_DIM, OUT_DIM);
        5: set_size(SRC_MAX, SRC_MAX);
        6: set_size(0, 2047);
        7: set_size($urandom_range(1, 16), $urandom_range(1, 16));
        8: set_size($urandom_range(1, 64), $urandom_range(1, 64));
        default: set_size($urandom_range(0, 2047), $urandom_range(0, 2047));
      endcase
      random_traffic(PHASE_ITEMS);
    end
  endtask

  // Stop the sender mid-stream until the result side is empty, then carry on
  task automatic test_pause_mid_stream();
    set_size(7, 11);
    random_traffic(30);
    drain_results();
    random_traffic(30);
  endtask

  // Compare each result strobe with the oldest prediction, field by field
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_pixels.size() == 0) begin
        report_fault($sformatf("result with nothing pending: %h", out_item));
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        if (out_item.red_value !== oldest_pixel.red_value ||
            out_item.green_value !== oldest_pixel.green_value ||
            out_item.blue_value !== oldest_pixel.blue_value ||
            out_item.alpha_value !== oldest_pixel.alpha_value)
          report_fault($sformatf("rgba expected %h %h %h %h got %h %h %h %h",
                                 oldest_pixel.red_value, oldest_pixel.green_value,
                                 oldest_pixel.blue_value, oldest_pixel.alpha_value,
                                 out_item.red_value, out_item.green_value,
                                 out_item.blue_value, out_item.alpha_value));
      end
    end
  end

  // Watchdog: too long with neither an accepted transaction nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_bilinear_image_resize: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size_copy();
    test_size_extremes();
    test_size_change();
    test_random_sizes();
    test_pause_mid_stream();
    drain_results();
    if (fault_count == 0) begin
      $display("tb_bilinear_image_resize: done, clean");
    end else begin
      $display("tb_bilinear_image_resize: done, errors");
    end
    $finish;
  end

endmodule
